// File: rtl/core/utrsi_pkg.sv
// ============================================================================
// utrsi_pkg
// Shared types and constants of the up-the-ramp slope integrator: command
// codes, register indexes, the per-pixel ramp record and pipeline payloads.
// ============================================================================
`default_nettype none

package utrsi_pkg;

    // Item commands
    typedef enum logic [1:0] {
        CMD_INIT   = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_FINISH = 2'd2
    } cmd_t;

    // Configuration register indexes
    localparam int          CFG_IDX_W  = 4;
    localparam logic [3:0]  REG_CUTOFF = 4'd0;
    localparam logic [3:0]  REG_NOISE  = 4'd1;
    localparam logic [3:0]  REG_WELL   = 4'd2;
    localparam logic [3:0]  REG_GAIN   = 4'd3;

    // Register reset values
    localparam logic [7:0]  CUTOFF_RST = 8'd5;
    localparam logic [15:0] NOISE_RST  = 16'd2250;
    localparam logic [15:0] WELL_RST   = 16'd32000;
    localparam logic [7:0]  GAIN_RST   = 8'd1;

    // Finish dividers: numerator width and divisor widths
    localparam int QUO_W  = 63;
    localparam int DEN1_W = 40;
    localparam int DEN2_W = 55;
    localparam int DEN3_W = 25;

    // Q8 limits
    localparam logic signed [65:0] Q8_MAX = 66'sd8388607;
    localparam logic signed [65:0] Q8_MIN = -66'sd8388608;

    // Per-pixel ramp record
    typedef struct packed {
        logic [16:0] w;   // ramp weight
        logic [31:0] s;   // weighted sum, signed
        logic [21:0] t;   // running total
        logic [15:0] z;   // last sample
        logic [23:0] a;   // summed difference, signed
        logic [6:0]  n;   // current run
        logic [6:0]  m;   // good count
    } rec_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [18:0] pix;
    } ctl_t;

    // Update operands carried down to write back
    typedef struct packed {
        logic [15:0] r;
        rec_t        prev;
        logic [16:0] x;      // r - z, signed
        logic [6:0]  n1;     // run plus one
        logic [13:0] winc;   // n1*(n1+1)/2
        logic [22:0] nr;     // n1*r
    } upd_t;

    typedef struct packed {
        ctl_t        ctl;
        upd_t        u;
        logic [16:0] wd;
        logic [34:0] xw;
        logic [40:0] cs;
        logic [32:0] ew;
        logic [39:0] ms;
        logic [57:0] sea;
        logic [24:0] wg;
        logic [14:0] mg;
    } st2_t;

    typedef struct packed {
        ctl_t        ctl;
        upd_t        u;
        logic [35:0] d;
        logic [58:0] csw;
        logic [49:0] eww;
        logic [40:0] den;
        logic [65:0] num;
        logic [24:0] wg;
        logic [14:0] mg;
    } st3_t;

    typedef struct packed {
        ctl_t        ctl;
        upd_t        u;
        logic [63:0] sq;
        logic        big;
        logic [59:0] rhs;
        logic [62:0] abs_num;
        logic [39:0] abs_den;
        logic [54:0] den2;
        logic [24:0] wg;
        logic        neg;
        logic        f_den;
        logic        f_wg;
        logic        f_mg;
    } st4_t;

    // Sideband traveling beside the dividers
    typedef struct packed {
        logic [18:0] pix;
        logic        neg;
        logic        f_den;
        logic        f_wg;
        logic        f_mg;
    } fin_t;

    // Saturate to a signed 24-bit Q8 value
    function automatic logic [23:0] sat24(input logic signed [65:0] v);
        logic [23:0] res;
        if (v > Q8_MAX) begin
            res = 24'h7FFFFF;
        end else if (v < Q8_MIN) begin
            res = 24'h800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/up_the_ramp_slope_integrator.sv
// Throughput: one item per cycle unless a finished result waits on a stalled output;
// an item whose pixel is still being written back by one of the four read-modify-write
// stages waits until that write lands.
// The finish quotients come from three 63-stage bit-per-stage dividers.
// Reset: control state and configuration registers return to defaults at once;
// the pixel record memory is not cleared and holds garbage until init writes an entry.
// ============================================================================
// up_the_ramp_slope_integrator
// Per-pixel up-the-ramp accumulation with full-well and glitch rejection and
// an optimal-weighting slope and variance estimate on finish.
// ============================================================================
`default_nettype none

module up_the_ramp_slope_integrator
    import utrsi_pkg::*;
#(
    parameter int NUM_PIXELS = 524288
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           command,
    input  wire logic [18:0]          pixel_index,
    input  wire logic [15:0]          sample,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [18:0]               out_pixel,
    output logic signed [23:0]        signal,
    output logic signed [23:0]        variance,
    output logic                      divide_fault,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    localparam int IDX_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  cutoff_reg;
    logic [15:0] noise_reg;
    logic [15:0] well_reg;
    logic [7:0]  gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= CUTOFF_RST;
            noise_reg  <= NOISE_RST;
            well_reg   <= WELL_RST;
            gain_reg   <= GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CUTOFF: cutoff_reg <= cfg_data[7:0];
                REG_NOISE:  noise_reg  <= cfg_data;
                REG_WELL:   well_reg   <= cfg_data;
                REG_GAIN:   gain_reg   <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic             adv;
    logic             hazard;
    logic             in_range;
    logic             take;
    logic [31:0]      pix_ext;
    logic [IDX_W-1:0] idx_in;
    cmd_t             cmd_in;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    ctl_t ctl1_reg;
    logic [15:0] r1_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    rec_t rd_reg;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    st4_t s4_reg, s4_next;

    localparam int DIV_STAGES = QUO_W;
    logic fin_valid_reg [DIV_STAGES];
    fin_t fin_reg       [DIV_STAGES];

    logic out_valid_reg;

    // hold everything only when a finished result would collide with a waiting one
    assign adv = !(out_valid_reg && !out_ready && fin_valid_reg[DIV_STAGES-1]);

    assign pix_ext  = 32'(pixel_index);
    assign in_range = (pix_ext < 32'(NUM_PIXELS));
    assign idx_in   = pix_ext[IDX_W-1:0];
    assign cmd_in   = cmd_t'(command);

    // interlock: the pixel must not be pending write back in any stage
    assign hazard = (v1_reg && ctl1_reg.cmd != CMD_FINISH && ctl1_reg.pix == pixel_index)
                 || (v2_reg && s2_reg.ctl.cmd != CMD_FINISH && s2_reg.ctl.pix == pixel_index)
                 || (v3_reg && s3_reg.ctl.cmd != CMD_FINISH && s3_reg.ctl.pix == pixel_index)
                 || (v4_reg && s4_reg.ctl.cmd != CMD_FINISH && s4_reg.ctl.pix == pixel_index);

    assign in_ready = adv && !hazard;
    assign take     = in_valid && in_ready && in_range
                   && (cmd_in == CMD_INIT || cmd_in == CMD_UPDATE || cmd_in == CMD_FINISH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Pixel record memory
    // ------------------------------------------------------------------
    rec_t rec_mem [NUM_PIXELS];
    rec_t wr_rec;
    logic wr_en;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg <= rec_mem[idx_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rec_mem[idx4_reg] <= wr_rec;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture transaction, memory read in flight
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl1_reg.cmd <= cmd_in;
            ctl1_reg.pix <= pixel_index;
            r1_reg       <= sample;
            idx1_reg     <= idx_in;
            idx2_reg     <= idx1_reg;
            idx3_reg     <= idx2_reg;
            idx4_reg     <= idx3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: first products from the record
    // ------------------------------------------------------------------
    logic [16:0] wd1;
    logic [16:0] x1;
    logic [25:0] ea1;
    logic [6:0]  n1_1;
    logic [7:0]  n1p1;
    logic [14:0] tri_prod;

    assign wd1      = (rd_reg.w == 17'd0) ? 17'd1 : rd_reg.w;
    assign x1       = {1'b0, r1_reg} - {1'b0, rd_reg.z};
    assign ea1      = 26'($signed(rd_reg.a)) + 26'({noise_reg, 2'b00});
    assign n1_1     = rd_reg.n + 7'd1;
    assign n1p1     = {1'b0, n1_1} + 8'd1;
    assign tri_prod = 15'(n1_1) * 15'(n1p1);

    always_comb
    begin
        s2_next.ctl       = ctl1_reg;
        s2_next.u.r       = r1_reg;
        s2_next.u.prev    = rd_reg;
        s2_next.u.x       = x1;
        s2_next.u.n1      = n1_1;
        s2_next.u.winc    = tri_prod[14:1];
        s2_next.u.nr      = 23'(n1_1) * 23'(r1_reg);
        s2_next.wd        = wd1;
        s2_next.xw        = 35'($signed(x1)) * 35'($signed({1'b0, wd1}));
        s2_next.cs        = 41'($signed({1'b0, cutoff_reg})) * 41'($signed(rd_reg.s));
        s2_next.ew        = 33'(noise_reg) * 33'(wd1);
        s2_next.ms        = 40'($signed({1'b0, rd_reg.m})) * 40'($signed(rd_reg.s));
        s2_next.sea       = 58'($signed(rd_reg.s)) * 58'($signed(ea1));
        s2_next.wg        = 25'(wd1) * 25'(gain_reg);
        s2_next.mg        = 15'(rd_reg.m) * 15'(gain_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg <= s2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: residual, threshold products, finish denominator
    // ------------------------------------------------------------------
    always_comb
    begin
        s3_next.ctl = s2_reg.ctl;
        s3_next.u   = s2_reg.u;
        s3_next.d   = 36'($signed(s2_reg.xw)) - 36'($signed(s2_reg.u.prev.s));
        s3_next.csw = 59'($signed(s2_reg.cs)) * 59'($signed({1'b0, s2_reg.wd}));
        s3_next.eww = 50'(s2_reg.ew) * 50'(s2_reg.wd);
        s3_next.den = 41'($signed(s2_reg.ms)) + 41'({s2_reg.ew, 2'b00});
        s3_next.num = {s2_reg.sea, 8'h00};
        s3_next.wg  = s2_reg.wg;
        s3_next.mg  = s2_reg.mg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg <= s3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: square the residual, sum threshold, magnitudes for division
    // ------------------------------------------------------------------
    logic [35:0] ad3;
    logic [65:0] abs_num3;
    logic [40:0] abs_den3;

    assign ad3      = s3_reg.d[35] ? (36'd0 - s3_reg.d) : s3_reg.d;
    assign abs_num3 = s3_reg.num[65] ? (66'd0 - s3_reg.num) : s3_reg.num;
    assign abs_den3 = s3_reg.den[40] ? (41'd0 - s3_reg.den) : s3_reg.den;

    always_comb
    begin
        s4_next.ctl     = s3_reg.ctl;
        s4_next.u       = s3_reg.u;
        s4_next.sq      = 64'(ad3[31:0]) * 64'(ad3[31:0]);
        s4_next.big     = |ad3[35:32];
        s4_next.rhs     = 60'($signed(s3_reg.csw)) + 60'(s3_reg.eww);
        s4_next.abs_num = abs_num3[62:0];
        s4_next.abs_den = abs_den3[39:0];
        s4_next.den2    = 55'(abs_den3[39:0]) * 55'(s3_reg.mg);
        s4_next.wg      = s3_reg.wg;
        s4_next.neg     = s3_reg.num[65] ^ s3_reg.den[40];
        s4_next.f_den   = (s3_reg.den == 41'd0);
        s4_next.f_wg    = (s3_reg.wg == 25'd0);
        s4_next.f_mg    = (s3_reg.mg == 15'd0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_reg <= s4_next;
        end
    end

    // ------------------------------------------------------------------
    // Write back: glitch decision and new record
    // ------------------------------------------------------------------
    logic good;
    upd_t u4;

    assign u4   = s4_reg.u;
    assign good = !s4_reg.rhs[59] && (s4_reg.rhs != 60'd0) && !s4_reg.big
               && (s4_reg.sq < 64'(s4_reg.rhs));

    always_comb
    begin
        wr_rec = u4.prev;
        if (s4_reg.ctl.cmd == CMD_INIT)
        begin
            wr_rec   = '0;
            wr_rec.t = 22'(u4.r);
            wr_rec.z = u4.r;
        end
        else if (u4.r >= well_reg)
        begin
            // saturated: restart the run
            wr_rec.n = 7'd0;
            wr_rec.z = u4.r;
            wr_rec.t = 22'(u4.r);
        end
        else if (good)
        begin
            wr_rec.n = u4.n1;
            wr_rec.m = u4.prev.m + 7'd1;
            wr_rec.a = u4.prev.a + {{7{u4.x[16]}}, u4.x};
            wr_rec.w = u4.prev.w + 17'(u4.winc);
            wr_rec.s = u4.prev.s + 32'(u4.nr) - 32'(u4.prev.t);
            wr_rec.t = u4.prev.t + 22'(u4.r);
            wr_rec.z = u4.r;
        end
        else if (u4.prev.m <= 7'd1)
        begin
            // glitch early in the ramp: start over from this difference
            wr_rec.w = 17'd1;
            wr_rec.s = {{15{u4.x[16]}}, u4.x};
            wr_rec.a = {{7{u4.x[16]}}, u4.x};
            wr_rec.m = 7'd1;
            wr_rec.n = 7'd1;
            wr_rec.t = 22'(u4.r) + 22'(u4.prev.z);
            wr_rec.z = u4.r;
        end
        else
        begin
            // glitch: drop the sample, restart the run
            wr_rec.n = 7'd0;
            wr_rec.z = u4.r;
            wr_rec.t = 22'(u4.r);
        end
    end

    assign wr_en = adv && v4_reg && (s4_reg.ctl.cmd != CMD_FINISH);

    // ------------------------------------------------------------------
    // Finish dividers
    // ------------------------------------------------------------------
    logic [QUO_W-1:0] q1, q2, q3;

    utrsi_div #(.NUM_W(QUO_W), .DEN_W(DEN1_W)) u_div_sig (
        .clk (clk),
        .en  (adv),
        .num (s4_reg.abs_num),
        .den (s4_reg.abs_den),
        .quo (q1)
    );

    utrsi_div #(.NUM_W(QUO_W), .DEN_W(DEN2_W)) u_div_run (
        .clk (clk),
        .en  (adv),
        .num (s4_reg.abs_num),
        .den (s4_reg.den2),
        .quo (q2)
    );

    utrsi_div #(.NUM_W(QUO_W), .DEN_W(DEN3_W)) u_div_noise (
        .clk (clk),
        .en  (adv),
        .num (QUO_W'({noise_reg, 8'h00})),
        .den (s4_reg.wg),
        .quo (q3)
    );

    // Sideband delay line beside the dividers
    fin_t fin_in;

    assign fin_in = '{pix:   s4_reg.ctl.pix,
                      neg:   s4_reg.neg,
                      f_den: s4_reg.f_den,
                      f_wg:  s4_reg.f_wg,
                      f_mg:  s4_reg.f_mg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                fin_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            fin_valid_reg[0] <= v4_reg && (s4_reg.ctl.cmd == CMD_FINISH);
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                fin_valid_reg[i] <= fin_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fin_reg[0] <= fin_in;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                fin_reg[i] <= fin_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result assembly and output register
    // ------------------------------------------------------------------
    fin_t                fin_last;
    logic signed [64:0]  sig_full;
    logic signed [64:0]  run_term;
    logic signed [65:0]  var_full;
    logic [23:0]         signal_next;
    logic [23:0]         variance_next;
    logic                fault_next;

    logic [18:0] out_pixel_reg;
    logic [23:0] signal_reg;
    logic [23:0] variance_reg;
    logic        fault_reg;

    assign fin_last = fin_reg[DIV_STAGES-1];

    always_comb
    begin
        sig_full = '0;
        run_term = '0;
        if (!fin_last.f_den)
        begin
            sig_full = fin_last.neg ? (65'sd0 - $signed(65'(q1))) : $signed(65'(q1));
            if (!fin_last.f_mg)
            begin
                run_term = fin_last.neg ? (65'sd0 - $signed(65'(q2))) : $signed(65'(q2));
            end
        end
        var_full = 66'(run_term) + (fin_last.f_wg ? 66'sd0 : $signed(66'(q3)));
        signal_next   = sat24(66'(sig_full));
        variance_next = sat24(var_full);
        fault_next    = fin_last.f_den | fin_last.f_wg | fin_last.f_mg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && fin_valid_reg[DIV_STAGES-1])
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && fin_valid_reg[DIV_STAGES-1])
        begin
            out_pixel_reg <= fin_last.pix;
            signal_reg    <= signal_next;
            variance_reg  <= variance_next;
            fault_reg     <= fault_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_pixel    = out_pixel_reg;
    assign signal       = signal_reg;
    assign variance     = variance_reg;
    assign divide_fault = fault_reg;

endmodule

`default_nettype wire

// File: rtl/core/utrsi_div.sv
// ============================================================================
// utrsi_div
// Unsigned restoring divider, one quotient bit per pipeline stage.
// A zero divisor gives an all-ones quotient; the caller masks it.
// ============================================================================
`default_nettype none

module utrsi_div #(
    parameter int NUM_W = 63,
    parameter int DEN_W = 40
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] acc_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] acc_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             fits;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign acc_in = num;
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign acc_in = acc_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        // shift in the next numerator bit and try a subtract
        assign trial = {rem_in, acc_in[NUM_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign fits  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                acc_reg[i] <= {acc_in[NUM_W-2:0], fits};
                den_reg[i] <= den_in;
            end
        end
    end

    assign quo = acc_reg[NUM_W-1];

endmodule

`default_nettype wire

// File: rtl/core/utrsi_checker.sv
// ============================================================================
// utrsi_props
// Port-level checks on the slope integrator, bound to the top level.
// ============================================================================
`default_nettype none

module utrsi_props (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic        [18:0] out_pixel,
    input wire logic signed [23:0] signal,
    input wire logic signed [23:0] variance,
    input wire logic               divide_fault
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    // keep the stalled payload steady
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(signal) && $stable(variance)
                                    && $stable(out_pixel) && $stable(divide_fault))
        else $error("result payload changed while stalled");

    // no result can leave the pipeline right after reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result right after reset");

    // with all divisors valid, a non-negative slope gives a non-negative variance
    a_var_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !divide_fault && !signal[23] |-> !variance[23])
        else $error("negative variance with non-negative slope");

endmodule

bind up_the_ramp_slope_integrator utrsi_props u_utrsi_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel    (out_pixel),
    .signal       (signal),
    .variance     (variance),
    .divide_fault (divide_fault)
);

`default_nettype wire

// File: test/utrsi_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// utrsi_checker
// Watches the item, result and register channels of the slope integrator,
// predicts each finish result from its own per-pixel ramp records and
// compares every result transaction field by field, in order.
// ============================================================================

module utrsi_checker
    import utrsi_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic [1:0]           command,
    input  wire logic [18:0]          pixel_index,
    input  wire logic [15:0]          sample,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic [18:0]          out_pixel,
    input  wire logic signed [23:0]   signal,
    input  wire logic signed [23:0]   variance,
    input  wire logic                 divide_fault,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic [18:0] pix;
        logic [23:0] sig;
        logic [23:0] var_q8;
        logic        fault;
    } slope_est_t;

    slope_est_t  est_queue[$];
    rec_t        ramps[int unsigned];
    logic [7:0]  cutoff;
    logic [15:0] noise;
    logic [15:0] well;
    logic [7:0]  gain_r;

    assign pending = est_queue.size();

    function automatic logic [23:0] clamp_q8(longint v);
        if (v > 64'sd8388607) return 24'h7FFFFF;
        if (v < -64'sd8388608) return 24'h800000;
        return v[23:0];
    endfunction

    // Exact glitch test: (x*W - s)^2 < C*s*W + E*W*W
    function automatic bit sample_good(longint x, longint s, longint wd);
        longint d;
        longint rhs;
        longint unsigned ad;
        d   = x * wd - s;
        rhs = longint'(cutoff) * s * wd + longint'(noise) * wd * wd;
        ad  = (d < 0) ? longint'(-d) : d;
        if (rhs <= 0) return 1'b0;
        if (ad >= 64'd4294967296) return 1'b0;
        return (ad * ad) < longint'(rhs);
    endfunction

    function automatic rec_t ramp_update(rec_t c, logic [15:0] r);
        longint x;
        longint wd;
        longint s;
        longint nn;
        x = longint'(r) - longint'(c.z);
        if (r >= well) begin
            c.n = '0;
            c.z = r;
            c.t = 22'(r);
        end else begin
            wd = (c.w != 0) ? longint'(c.w) : 1;
            s  = longint'(signed'(c.s));
            if (sample_good(x, s, wd)) begin
                c.n = c.n + 7'd1;
                c.m = c.m + 7'd1;
                c.a = c.a + x[23:0];
                nn  = longint'(c.n);
                c.w = c.w + 17'(nn * (nn + 1) / 2);
                c.s = c.s + 32'(nn * longint'(r)) - 32'(c.t);
                c.t = c.t + 22'(r);
                c.z = r;
            end else if (c.m <= 7'd1) begin
                c.w = 17'd1;
                c.s = x[31:0];
                c.a = x[23:0];
                c.m = 7'd1;
                c.n = 7'd1;
                c.t = 22'(r) + 22'(c.z);
                c.z = r;
            end else begin
                c.n = '0;
                c.z = r;
                c.t = 22'(r);
            end
        end
        return c;
    endfunction

    function automatic slope_est_t slope_estimate(rec_t c, logic [18:0] pix);
        slope_est_t o;
        longint e, g, wd, s, a, m, den, sig, vq;
        e   = longint'(noise);
        g   = longint'(gain_r);
        wd  = (c.w != 0) ? longint'(c.w) : 1;
        s   = longint'(signed'(c.s));
        a   = longint'(signed'(c.a));
        m   = longint'(c.m);
        den = m * s + 4 * wd * e;
        sig = 0;
        vq  = 0;
        o.fault = 1'b0;
        if (den == 0) o.fault = 1'b1;
        else sig = (s * (4 * e + a) * 256) / den;
        if (wd * g == 0) o.fault = 1'b1;
        else vq += (e * 256) / (wd * g);
        if (m * g == 0) o.fault = 1'b1;
        else vq += sig / (m * g);
        o.pix    = pix;
        o.sig    = clamp_q8(sig);
        o.var_q8 = clamp_q8(vq);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slope_est_t exp_r;
        rec_t       c;
        if (!rst_n) begin
            cutoff     <= CUTOFF_RST;
            noise      <= NOISE_RST;
            well       <= WELL_RST;
            gain_r     <= GAIN_RST;
            fail_count <= 0;
        end else begin
            // compare a result transaction against the oldest estimate
            if (out_valid && out_ready) begin
                if (est_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result pixel %0d", $realtime, out_pixel);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = est_queue.pop_front();
                    if (out_pixel !== exp_r.pix || signal !== exp_r.sig
                        || variance !== exp_r.var_q8 || divide_fault !== exp_r.fault) begin
                        if (fail_count < 10)
                            $display("%0t: mismatch exp pix %0d sig %0d var %0d flt %0b, got pix %0d sig %0d var %0d flt %0b",
                                $realtime, exp_r.pix, $signed(exp_r.sig), $signed(exp_r.var_q8),
                                exp_r.fault, out_pixel, signal, variance, divide_fault);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // apply a register write
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CUTOFF: cutoff <= cfg_data[7:0];
                    REG_NOISE:  noise  <= cfg_data;
                    REG_WELL:   well   <= cfg_data;
                    REG_GAIN:   gain_r <= cfg_data[7:0];
                    default: ;
                endcase
            end
            // advance the ramp records on an item transaction
            if (in_valid && in_ready) begin
                c = ramps.exists(pixel_index) ? ramps[pixel_index] : '0;
                case (command)
                    CMD_INIT: begin
                        c   = '0;
                        c.t = 22'(sample);
                        c.z = sample;
                        ramps[pixel_index] = c;
                    end
                    CMD_UPDATE: ramps[pixel_index] = ramp_update(c, sample);
                    CMD_FINISH: est_queue.push_back(slope_estimate(c, pixel_index));
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Drives the slope integrator with directed and random ramp sequences under
// several register settings, with random idling on both channels; the
// checker predicts and compares, this module gives the verdict.
// ============================================================================

module tb_top;
    import utrsi_pkg::*;

    localparam int WATCH_LIMIT = 5000;
    localparam int SETTLE      = 90;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           command = '0;
    logic [18:0]          pixel_index = '0;
    logic [15:0]          sample = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [18:0]          out_pixel;
    logic signed [23:0]   signal;
    logic signed [23:0]   variance;
    logic                 divide_fault;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;
    int                   fail_count;
    int                   pending;

    logic in_taken = 1'b0;
    logic cfg_taken = 1'b0;
    logic any_taken = 1'b0;
    bit   calm = 1'b0;
    int   items_sent = 0;
    int   idle_cycles = 0;
    logic [18:0] live_pix[$];

    always #5 clk = ~clk;

    up_the_ramp_slope_integrator u_top (.*);

    utrsi_checker u_chk (.*);

    // record handshakes for the negedge-driven stimulus
    always @(posedge clk)
    begin
        in_taken  <= in_valid && in_ready;
        cfg_taken <= cfg_valid && cfg_ready;
        any_taken <= (in_valid && in_ready) || (cfg_valid && cfg_ready)
                     || (out_valid && out_ready);
    end

    // watchdog: end the run after a long stretch with no transaction
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (any_taken) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side: stall in random bursts
    initial
    begin
        int burst;
        @(negedge clk);
        forever begin
            if (!calm && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 14);
                out_ready = 1'b0;
                repeat (burst) @(negedge clk);
            end
            out_ready = 1'b1;
            @(negedge clk);
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [18:0] pix, logic [15:0] smp);
        int burst;
        if (!calm && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 14);
            in_valid = 1'b0;
            repeat (burst) @(negedge clk);
        end
        command     = cmd;
        pixel_index = pix;
        sample      = smp;
        in_valid    = 1'b1;
        do @(negedge clk); while (!in_taken);
        items_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(negedge clk); while (!cfg_taken);
    endtask

    // drain the block, then load a new register setting
    task automatic load_setting(logic [7:0] cut, logic [15:0] nz, logic [15:0] wl,
                                logic [7:0] gn);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        write_reg(REG_CUTOFF, {8'd0, cut});
        write_reg(REG_NOISE, nz);
        write_reg(REG_WELL, wl);
        write_reg(REG_GAIN, {8'd0, gn});
        cfg_valid = 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] clip16(int v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    // interleaved ramps on a few pixels: init, frames, finish
    task automatic ramp_group();
        logic [18:0] pix[4];
        int base[4];
        int slope[4];
        int npix, frames, v;
        npix   = $urandom_range(1, 4);
        frames = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8);
        for (int k = 0; k < npix; k++) begin
            pix[k]   = $urandom;
            base[k]  = $urandom_range(0, 20000);
            slope[k] = $urandom_range(0, 300);
            send_item(CMD_INIT, pix[k], clip16(base[k]));
            live_pix.push_back(pix[k]);
        end
        for (int f = 1; f <= frames; f++) begin
            for (int k = 0; k < npix; k++) begin
                v = base[k] + slope[k] * f + $urandom_range(0, 40) - 20;
                case ($urandom_range(0, 15))
                    0: v = $urandom_range(0, 65535);
                    1: v = 65535;
                    default: ;
                endcase
                send_item(CMD_UPDATE, pix[k], clip16(v));
            end
        end
        for (int k = 0; k < npix; k++)
            send_item(CMD_FINISH, pix[k], 16'($urandom));
        if (live_pix.size() > 64) live_pix = live_pix[live_pix.size()-64:$];
    endtask

    // noise: random commands on live pixels, init and unused code anywhere
    task automatic noise_items();
        logic [1:0]  cmd;
        logic [18:0] pix;
        repeat ($urandom_range(1, 6)) begin
            cmd = $urandom_range(0, 3);
            pix = live_pix[$urandom_range(0, live_pix.size() - 1)];
            if (cmd == 2'd3 || cmd == CMD_INIT) pix = $urandom;
            if (cmd == CMD_INIT) live_pix.push_back(pix);
            send_item(cmd, pix, 16'($urandom));
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, every command, rejection paths
        send_item(CMD_INIT, 19'd0, 16'd0);
        send_item(CMD_INIT, 19'h7FFFF, 16'hFFFF);
        send_item(CMD_FINISH, 19'd0, 16'd0);
        send_item(CMD_UPDATE, 19'd0, 16'd100);
        send_item(CMD_UPDATE, 19'h7FFFF, 16'hFFFF);
        send_item(CMD_UPDATE, 19'd0, 16'd200);
        send_item(2'd3, 19'h7FFFF, 16'hFFFF);
        send_item(CMD_FINISH, 19'd0, 16'hFFFF);
        send_item(CMD_FINISH, 19'h7FFFF, 16'd0);
        send_item(CMD_INIT, 19'd5, 16'd1000);
        send_item(CMD_UPDATE, 19'd5, 16'd1010);
        send_item(CMD_UPDATE, 19'd5, 16'd30000);
        send_item(CMD_UPDATE, 19'd5, 16'd30010);
        send_item(CMD_UPDATE, 19'd5, 16'd30020);
        send_item(CMD_UPDATE, 19'd5, 16'd40);
        send_item(CMD_UPDATE, 19'd5, 16'd32000);
        send_item(CMD_UPDATE, 19'd5, 16'd31999);
        send_item(CMD_FINISH, 19'd5, 16'd0);
        live_pix.push_back(19'd0);
        live_pix.push_back(19'h7FFFF);
        live_pix.push_back(19'd5);

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_setting(8'd5, 16'd2250, 16'd32000, 8'd1);
                1: load_setting(8'd0, 16'd0, 16'd0, 8'd255);
                2: load_setting(8'd255, 16'hFFFF, 16'hFFFF, 8'd1);
                3: load_setting(8'd0, 16'd0, 16'hFFFF, 8'd1);
                4: load_setting($urandom_range(0, 255), $urandom, $urandom_range(20000, 65535),
                                $urandom_range(1, 255));
                default: load_setting(8'd5, 16'd2250, 16'd40000, 8'd3);
            endcase
            if (ph == 5) calm = 1'b1;
            while (items_sent < 18 + (ph + 1) * 270) begin
                if ($urandom_range(0, 6) == 0) noise_items();
                else ramp_group();
            end
        end

        // drain and verdict
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/utrsi_pkg.sv
rtl/core/utrsi_div.sv
rtl/core/up_the_ramp_slope_integrator.sv
rtl/core/utrsi_checker.sv
test/utrsi_checker.sv
test/tb_top.sv
